// ----- rtl/frws_pkg.sv -----
// ----------------------------------------------------------------------------
// frws_pkg
// Shared widths, constants and types of the frame rate window statistics block.
// ----------------------------------------------------------------------------
package frws_pkg;

  localparam int TICK_W   = 20;
  localparam int SUM_W    = 21;
  localparam int CNT_W    = 16;
  localparam int RATE_W   = 24;
  localparam int TPS_W    = 20;

  localparam logic [TPS_W-1:0] TICKS_PER_SECOND   = 20'd1000000;
  localparam int               RATE_FRACTION_BITS = 8;

  localparam int PROD_W = CNT_W + TPS_W;
  localparam int NUM_W  = PROD_W + RATE_FRACTION_BITS;
  localparam int CMP_W  = (NUM_W > SUM_W + RATE_W) ? NUM_W : SUM_W + RATE_W;
  localparam int STEP_W = $clog2(RATE_W);

  localparam logic [TICK_W-1:0] WINDOW_RESET = 20'd1000000;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } frws_state_t;

endpackage

// ----- rtl/frame_rate_window_statistics_top.sv -----
// ----------------------------------------------------------------------------
// frame_rate_window_statistics_top
// Frame counter with windowed rate, minimum, maximum and halving average.
// ----------------------------------------------------------------------------
// Each accepted item is one frame event with its elapsed ticks. An item that
// does not close the window goes straight to the finish state, which gives
// its result once the output register is free. An item that closes the window
// passes through accumulate, one multiply of the frame count by the tick rate,
// a range check, 24 steps of a serial restoring divider and the statistics
// update. A saturated rate skips the divider. in_ready is high only while
// the sequencer is idle, and one result may wait in the output register
// while the next item is being worked on.
module frame_rate_window_statistics_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [frws_pkg::TICK_W-1:0] in_frame_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_window_closed,
  output logic [frws_pkg::RATE_W-1:0] out_window_rate,
  output logic [frws_pkg::RATE_W-1:0] out_min_rate,
  output logic [frws_pkg::RATE_W-1:0] out_max_rate,
  output logic [frws_pkg::RATE_W-1:0] out_avg_rate,
  input  logic                        cfg_wr_en,
  input  logic [frws_pkg::TICK_W-1:0] cfg_wr_data
);

  localparam int SUM_W  = frws_pkg::SUM_W;
  localparam int RATE_W = frws_pkg::RATE_W;
  localparam int NUM_W  = frws_pkg::NUM_W;
  localparam int CMP_W  = frws_pkg::CMP_W;
  localparam int PROD_W = frws_pkg::PROD_W;
  localparam int STEP_W = frws_pkg::STEP_W;

  frws_pkg::frws_state_t state_r, state_nxt;

  logic [frws_pkg::TICK_W-1:0] win_r, win_nxt;
  logic [frws_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic                        closed_r, closed_nxt;
  logic [frws_pkg::CNT_W-1:0]  opcnt_r, opcnt_nxt;
  logic [SUM_W-1:0]            ticks_r, ticks_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic [SUM_W-1:0]            rem_r, rem_nxt;
  logic [RATE_W-1:0]           q_r, q_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [RATE_W-1:0]           lowest_r, lowest_nxt;
  logic [RATE_W-1:0]           highest_r, highest_nxt;
  logic [RATE_W-1:0]           mean_r, mean_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        o_closed_r, o_closed_nxt;
  logic [RATE_W-1:0]           o_rate_r, o_rate_nxt;
  logic [RATE_W-1:0]           o_min_r, o_min_nxt;
  logic [RATE_W-1:0]           o_max_r, o_max_nxt;
  logic [RATE_W-1:0]           o_avg_r, o_avg_nxt;

  logic [frws_pkg::CNT_W-1:0]  cnt_inc;
  logic [SUM_W:0]              sum_ext;
  logic [SUM_W-1:0]            sum_sat;
  logic                        close_now;
  logic [NUM_W-1:0]            num;
  logic                        sat;
  logic [SUM_W:0]              trial;
  logic [SUM_W:0]              diff;
  logic                        ge;
  logic [RATE_W-1:0]           rate;
  logic [RATE_W:0]             avg_sum;
  logic                        out_free;

  assign in_ready          = (state_r == frws_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_window_closed = o_closed_r;
  assign out_window_rate   = o_rate_r;
  assign out_min_rate      = o_min_r;
  assign out_max_rate      = o_max_r;
  assign out_avg_rate      = o_avg_r;

  assign cnt_inc   = (cnt_r == frws_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign sum_ext   = (SUM_W+1)'(sum_r) + (SUM_W+1)'(in_frame_time);
  assign sum_sat   = sum_ext[SUM_W] ? frws_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
  assign close_now = (sum_sat >= SUM_W'(win_r));

  assign num   = NUM_W'(prod_r) << frws_pkg::RATE_FRACTION_BITS;
  assign sat   = (ticks_r == '0) ||
                 (CMP_W'(num) >= (CMP_W'(ticks_r) << RATE_W));
  assign trial = {rem_r, q_r[RATE_W-1]};
  assign diff  = trial - {1'b0, ticks_r};
  assign ge    = (trial >= {1'b0, ticks_r});

  assign rate     = closed_r ? q_r : '0;
  assign avg_sum  = (RATE_W+1)'(mean_r) + (RATE_W+1)'(rate);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    closed_nxt    = closed_r;
    opcnt_nxt     = opcnt_r;
    ticks_nxt     = ticks_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    lowest_nxt    = lowest_r;
    highest_nxt   = highest_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r;
    o_closed_nxt  = o_closed_r;
    o_rate_nxt    = o_rate_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_avg_nxt     = o_avg_r;

    if (cfg_wr_en) begin
      win_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      frws_pkg::ST_IDLE: begin
        if (in_valid) begin
          closed_nxt = close_now;
          if (close_now) begin
            opcnt_nxt = cnt_inc;
            ticks_nxt = sum_sat;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = frws_pkg::ST_MUL;
          end else begin
            cnt_nxt   = cnt_inc;
            sum_nxt   = sum_sat;
            state_nxt = frws_pkg::ST_FIN;
          end
        end
      end
      frws_pkg::ST_MUL: begin
        prod_nxt  = PROD_W'(opcnt_r) * PROD_W'(frws_pkg::TICKS_PER_SECOND);
        state_nxt = frws_pkg::ST_LOAD;
      end
      frws_pkg::ST_LOAD: begin
        step_nxt = '0;
        if (sat) begin
          q_nxt     = frws_pkg::RATE_MAX;
          state_nxt = frws_pkg::ST_FIN;
        end else begin
          rem_nxt   = SUM_W'(num >> RATE_W);
          q_nxt     = num[RATE_W-1:0];
          state_nxt = frws_pkg::ST_DIV;
        end
      end
      frws_pkg::ST_DIV: begin
        rem_nxt  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        q_nxt    = {q_r[RATE_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(RATE_W - 1)) begin
          state_nxt = frws_pkg::ST_FIN;
        end
      end
      frws_pkg::ST_FIN: begin
        if (out_free) begin
          if (closed_r) begin
            if (rate < lowest_r || lowest_r == '0) begin
              lowest_nxt = rate;
            end
            if (rate > highest_r || highest_r == '0) begin
              highest_nxt = rate;
            end
            mean_nxt = (mean_r == '0) ? rate : avg_sum[RATE_W:1];
          end
          out_valid_nxt = 1'b1;
          o_closed_nxt  = closed_r;
          o_rate_nxt    = rate;
          o_min_nxt     = lowest_nxt;
          o_max_nxt     = highest_nxt;
          o_avg_nxt     = mean_nxt;
          state_nxt     = frws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frws_pkg::ST_IDLE;
      win_r       <= frws_pkg::WINDOW_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      lowest_r    <= '0;
      highest_r   <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    closed_r   <= closed_nxt;
    opcnt_r    <= opcnt_nxt;
    ticks_r    <= ticks_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    o_closed_r <= o_closed_nxt;
    o_rate_r   <= o_rate_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
    o_avg_r    <= o_avg_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after item accepted");

  a_open_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_closed |-> out_window_rate == '0)
    else $error("rate not zero for open window");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frws_pkg::ST_DIV |-> rem_r < ticks_r)
    else $error("divider remainder out of range");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_min_rate != '0 && out_max_rate != '0
    |-> out_min_rate <= out_max_rate)
    else $error("minimum above maximum");

endmodule
